FILE: rtl/core/rfps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfps_pkg;

    // scan function codes held in the mode register
    typedef enum logic [3:0] {
        MODE_SUM  = 4'd0,
        MODE_ALT  = 4'd1,
        MODE_AND  = 4'd2,
        MODE_OR   = 4'd3,
        MODE_NAND = 4'd4,
        MODE_NOR  = 4'd5,
        MODE_GT   = 4'd6,
        MODE_GE   = 4'd7,
        MODE_LT   = 4'd8,
        MODE_LE   = 4'd9,
        MODE_NE   = 4'd10,
        MODE_EQ   = 4'd11
    } t_mode;

    localparam int unsigned MODE_W = 4;
    localparam int unsigned SCAN_W = 32;

endpackage

`default_nettype wire

FILE: rtl/core/rfps_scan_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module rfps_scan_unit #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire rfps_pkg::t_mode                     i_mode,
    input  wire logic                                i_step,
    input  wire logic signed [rfps_pkg::SCAN_W-1:0]  i_value,
    input  wire logic                                i_start_req,
    output logic signed [rfps_pkg::SCAN_W-1:0]       o_scan
);

    // running state of the current vector
    logic [DATA_WIDTH-1:0] r_sum, n_sum;
    logic                  r_neg, r_seen, r_tpo, r_pos, r_rbit;
    logic                  n_seen, n_tpo, n_rbit;

    logic [DATA_WIDTH-1:0] sum_b;
    logic                  neg_b, seen_b, tpo_b, pos_b, rbit_b;
    logic [DATA_WIDTH-1:0] ext;
    logic                  bit_b, deciding, hit, res;

    // state as seen by this element, cleared by a vector start
    always_comb begin
        sum_b  = i_start_req ? '0   : r_sum;
        neg_b  = i_start_req ? 1'b0 : r_neg;
        seen_b = i_start_req ? 1'b0 : r_seen;
        tpo_b  = i_start_req ? 1'b0 : r_tpo;
        pos_b  = i_start_req ? 1'b0 : r_pos;
        rbit_b = i_start_req ? 1'b0 : r_rbit;
    end

    // element extended or truncated to the accumulator width
    assign ext   = DATA_WIDTH'(i_value);
    assign bit_b = i_value[0];

    // and, nand, greater and less-or-equal are decided by a zero bit
    assign deciding = !(i_mode == rfps_pkg::MODE_AND || i_mode == rfps_pkg::MODE_NAND ||
                        i_mode == rfps_pkg::MODE_GT  || i_mode == rfps_pkg::MODE_LE);

    assign hit    = !seen_b && (bit_b == deciding);
    assign n_seen = seen_b || hit;
    assign n_tpo  = hit ? pos_b : tpo_b;
    assign n_rbit = rbit_b ^ bit_b;

    // running sum or alternating difference
    assign n_sum = (i_mode == rfps_pkg::MODE_ALT && neg_b) ? sum_b - ext : sum_b + ext;

    // scan value for the prefix ending at this element
    always_comb begin
        res    = 1'b0;
        o_scan = '0;
        case (i_mode)
            rfps_pkg::MODE_SUM,
            rfps_pkg::MODE_ALT:  o_scan = rfps_pkg::SCAN_W'(n_sum);
            rfps_pkg::MODE_AND:  res = !n_seen;
            rfps_pkg::MODE_OR:   res = n_seen;
            rfps_pkg::MODE_NAND: res = !n_seen ? !pos_b : (hit ? n_tpo : !n_tpo);
            rfps_pkg::MODE_NOR:  res = !n_seen ? pos_b : (hit ? !n_tpo : n_tpo);
            rfps_pkg::MODE_GT:   res = !n_seen ? !pos_b : n_tpo;
            rfps_pkg::MODE_GE:   res = !n_seen ? pos_b : !n_tpo;
            rfps_pkg::MODE_LT:   res = hit;
            rfps_pkg::MODE_LE:   res = !hit;
            rfps_pkg::MODE_NE:   res = n_rbit;
            rfps_pkg::MODE_EQ:   res = n_rbit ^ pos_b;
            default:             o_scan = '0;
        endcase
        if (i_mode != rfps_pkg::MODE_SUM && i_mode != rfps_pkg::MODE_ALT) begin
            o_scan = {{(rfps_pkg::SCAN_W-1){1'b0}}, res};
        end
    end

    // state advances on every accepted element whatever the mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_neg  <= 1'b0;
            r_seen <= 1'b0;
            r_tpo  <= 1'b0;
            r_pos  <= 1'b0;
            r_rbit <= 1'b0;
        end else if (i_step) begin
            r_sum  <= n_sum;
            r_neg  <= !neg_b;
            r_seen <= n_seen;
            r_tpo  <= n_tpo;
            r_pos  <= !pos_b;
            r_rbit <= n_rbit;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/right_fold_prefix_scan_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Right-fold inclusive prefix scan, one vector element per transfer.
// Input channel: i_in_valid / o_in_stall with i_value and i_start_req;
// i_start_req marks the first element of a new vector. Output channel:
// o_out_valid / i_out_stall with o_scan, one result per input element,
// in order. The mode register is written through i_cfg_we / i_cfg_wdata
// and selects sum, alternating difference or one of ten boolean folds;
// write it only while no element is in flight.
// o_out_valid rises at the edge that takes the element when the output
// register is free, so its result can transfer at the following edge.
// Throughput: one element per cycle while o_in_stall is low, set by the
// single add-and-select pass between the state and result registers.
// A two-entry output stage (result register plus skid register) keeps
// o_in_stall registered; it rises only once both entries hold results,
// so one more element is taken after the receiver starts to stall.
// Reset clears the running state, the mode (sum) and both output entries;
// the first element after reset begins a vector even without i_start_req.
module right_fold_prefix_scan_core #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rfps_pkg::MODE_W-1:0]         i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [rfps_pkg::SCAN_W-1:0]  i_value,
    input  wire logic                                i_start_req,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [rfps_pkg::SCAN_W-1:0]       o_scan
);

    rfps_pkg::t_mode                    r_mode;
    logic                               r_out_valid, r_skid_valid;
    logic signed [rfps_pkg::SCAN_W-1:0] r_out_scan, r_skid_scan;
    logic signed [rfps_pkg::SCAN_W-1:0] scan_new;
    logic                               in_xfer, out_free;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rfps_pkg::MODE_SUM;
        end else if (i_cfg_we) begin
            r_mode <= rfps_pkg::t_mode'(i_cfg_wdata);
        end
    end

    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    rfps_scan_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_step      (in_xfer),
        .i_value     (i_value),
        .i_start_req (i_start_req),
        .o_scan      (scan_new)
    );

    // output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_scan <= r_skid_valid ? r_skid_scan : scan_new;
        end
        if (!out_free && in_xfer) begin
            r_skid_scan <= scan_new;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scan      = r_out_scan;

`ifndef NO_ASSERTIONS
    // skid entry is only ever occupied behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // element taken while the output is stalled lands in the skid entry
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("element lost while output stalled");

    // skid entry drains as soon as the output moves
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (!r_skid_valid && r_out_valid))
        else $error("skid entry did not drain");
`endif

endmodule

`default_nettype wire

FILE: bench/right_fold_prefix_scan_checker.sv
`timescale 1ns / 1ps

module right_fold_prefix_scan_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rfps_pkg::MODE_W-1:0]        i_cfg_wdata,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_stall,
    input  wire logic signed [rfps_pkg::SCAN_W-1:0] i_value,
    input  wire logic                               i_start_req,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_stall,
    input  wire logic signed [rfps_pkg::SCAN_W-1:0] i_scan,
    output int                                      o_pending,
    output int                                      o_fail_count
);

    localparam int REPORT_LIMIT = 10;

    // shadow of the mode register and the running fold state
    logic [rfps_pkg::MODE_W-1:0] cur_mode;
    logic [rfps_pkg::SCAN_W-1:0] acc_sum;
    logic                        sub_next;
    logic                        decided;
    logic                        decided_odd;
    logic                        pos_odd;
    logic                        parity;

    logic [rfps_pkg::SCAN_W-1:0] scan_expected_q[$];
    int                          fault_total = 0;
    int                          waiting     = 0;

    assign o_pending    = waiting;
    assign o_fail_count = fault_total;

    // bit value that settles the fold: zero for and, nand, greater, less-or-equal
    function automatic logic settling_bit(input logic [rfps_pkg::MODE_W-1:0] m);
        return !(m == rfps_pkg::MODE_AND || m == rfps_pkg::MODE_NAND ||
                 m == rfps_pkg::MODE_GT  || m == rfps_pkg::MODE_LE);
    endfunction

    // fold one element into the shadow state and return its prefix result
    function automatic logic [rfps_pkg::SCAN_W-1:0] fold_elem(
        input logic [rfps_pkg::SCAN_W-1:0] v,
        input logic                        first);
        logic                        b;
        logic                        pos;
        logic                        hit;
        logic                        seen;
        logic                        tp;
        logic                        res;
        logic [rfps_pkg::SCAN_W-1:0] r;

        if (first) begin
            acc_sum     = '0;
            sub_next    = 1'b0;
            decided     = 1'b0;
            decided_odd = 1'b0;
            pos_odd     = 1'b0;
            parity      = 1'b0;
        end

        b    = v[0];
        pos  = pos_odd;
        hit  = !decided && (b == settling_bit(cur_mode));
        seen = decided || hit;
        tp   = hit ? pos : decided_odd;

        if (cur_mode == rfps_pkg::MODE_ALT && sub_next) begin
            acc_sum = acc_sum - v;
        end else begin
            acc_sum = acc_sum + v;
        end

        res = 1'b0;
        r   = '0;
        case (cur_mode)
            rfps_pkg::MODE_SUM, rfps_pkg::MODE_ALT: r = acc_sum;
            rfps_pkg::MODE_AND:  res = !seen;
            rfps_pkg::MODE_OR:   res = seen;
            rfps_pkg::MODE_NAND: res = !seen ? !pos : (hit ? tp : !tp);
            rfps_pkg::MODE_NOR:  res = !seen ? pos : (hit ? !tp : tp);
            rfps_pkg::MODE_GT:   res = !seen ? !pos : tp;
            rfps_pkg::MODE_GE:   res = !seen ? pos : !tp;
            rfps_pkg::MODE_LT:   res = hit;
            rfps_pkg::MODE_LE:   res = !hit;
            rfps_pkg::MODE_NE:   res = parity ^ b;
            rfps_pkg::MODE_EQ:   res = parity ^ b ^ pos;
            default:             r = '0;
        endcase
        if (cur_mode >= rfps_pkg::MODE_AND && cur_mode <= rfps_pkg::MODE_EQ) begin
            r = {{(rfps_pkg::SCAN_W-1){1'b0}}, res};
        end

        sub_next    = !sub_next;
        decided     = seen;
        decided_odd = tp;
        pos_odd     = !pos;
        parity      = parity ^ b;
        return r;
    endfunction

    task automatic note_fault(input string what, input logic [rfps_pkg::SCAN_W-1:0] want,
                              input logic [rfps_pkg::SCAN_W-1:0] got);
        fault_total++;
        if (fault_total <= REPORT_LIMIT) begin
            $display("%0t: %s: scan expected %h got %h", $realtime, what, want, got);
        end
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin : watch
        logic [rfps_pkg::SCAN_W-1:0] want;

        if (!i_rst_n) begin
            cur_mode    = rfps_pkg::MODE_SUM;
            acc_sum     = '0;
            sub_next    = 1'b0;
            decided     = 1'b0;
            decided_odd = 1'b0;
            pos_odd     = 1'b0;
            parity      = 1'b0;
            scan_expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                cur_mode = i_cfg_wdata;
            end
            // input transfer
            if (i_in_valid && !i_in_stall) begin
                scan_expected_q.push_back(fold_elem(i_value, i_start_req));
            end
            // output transfer
            if (i_out_valid && !i_out_stall) begin
                if (scan_expected_q.size() == 0) begin
                    note_fault("unexpected result", 'x, i_scan);
                end else begin
                    want = scan_expected_q.pop_front();
                    if (i_scan !== want) begin
                        note_fault("mismatch", want, i_scan);
                    end
                end
            end
        end
        waiting = scan_expected_q.size();
    end

endmodule

FILE: bench/right_fold_prefix_scan_core_tb.sv
`timescale 1ns / 1ps

module right_fold_prefix_scan_core_tb;

    localparam int                          RANDOM_ITEMS   = 1100;
    localparam logic [rfps_pkg::SCAN_W-1:0] VAL_MAX        = 32'h7FFF_FFFF;
    localparam logic [rfps_pkg::SCAN_W-1:0] VAL_MIN        = 32'h8000_0000;
    localparam logic [rfps_pkg::SCAN_W-1:0] VAL_ONES       = 32'hFFFF_FFFF;
    localparam logic [rfps_pkg::MODE_W-1:0] MODE_SPARE_LOW = 4'd12;
    localparam logic [rfps_pkg::MODE_W-1:0] MODE_SPARE_TOP = 4'd15;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_cfg_we    = 1'b0;
    logic [rfps_pkg::MODE_W-1:0]        i_cfg_wdata = '0;
    logic                               i_in_valid  = 1'b0;
    logic signed [rfps_pkg::SCAN_W-1:0] i_value     = '0;
    logic                               i_start_req = 1'b0;
    logic                               i_out_stall = 1'b0;
    logic                               o_in_stall;
    logic                               o_out_valid;
    logic signed [rfps_pkg::SCAN_W-1:0] o_scan;

    int   pending_scans;
    int   scan_faults;
    logic steady_send = 1'b0;
    int   stall_left  = 0;

    right_fold_prefix_scan_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .i_start_req (i_start_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_scan      (o_scan)
    );

    right_fold_prefix_scan_checker scan_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_start_req  (i_start_req),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_scan       (o_scan),
        .o_pending    (pending_scans),
        .o_fail_count (scan_faults)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAIL right_fold_prefix_scan_core");
        $finish;
    end

    // receiver back-pressure: short bursts, the odd long stall, quiet stretches
    always @(posedge i_clk) begin : back_pressure
        int pick;

        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                i_out_stall <= 1'b0;
                stall_left  <= $urandom_range(0, 6);
            end else if (pick < 80) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(0, 2);
            end else if (pick < 93) begin
                i_out_stall <= 1'b0;
                stall_left  <= $urandom_range(20, 80);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(8, 40);
            end
        end
    end

    // sender idle cycles before a transfer
    function automatic int pick_gap();
        int pick;

        pick = $urandom_range(0, 99);
        if (steady_send || pick < 60) begin
            return 0;
        end else if (pick < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 25);
    endfunction

    // random element; bit 0 is chosen by the caller
    function automatic logic [rfps_pkg::SCAN_W-1:0] pick_value(input logic low_bit);
        logic [rfps_pkg::SCAN_W-1:0] v;
        int                          pick;

        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            v = $urandom;
        end else if (pick < 7) begin
            v = $urandom_range(0, 15) - 8;
        end else if (pick == 7) begin
            v = VAL_MAX;
        end else if (pick == 8) begin
            v = VAL_MIN;
        end else begin
            v = VAL_ONES;
        end
        v[0] = low_bit;
        return v;
    endfunction

    // one element transfer; returns at the edge where it is taken
    task automatic send_elem(input logic [rfps_pkg::SCAN_W-1:0] v, input logic first);
        int gap;

        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_value     <= v;
        i_start_req <= first;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_scans != 0) @(negedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [rfps_pkg::MODE_W-1:0] m);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        logic [rfps_pkg::MODE_W-1:0] m;
        int                          items_left;
        int                          phase_idx;
        int                          phase_len;
        int                          vec_left;
        int                          bias;
        logic                        fresh;
        logic                        first;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sum from reset without a start flag, wrapping both ways
        send_elem(VAL_MAX, 1'b0);
        send_elem(32'd1, 1'b0);
        send_elem(VAL_ONES, 1'b0);
        send_elem(VAL_MIN, 1'b1);
        send_elem(VAL_MIN, 1'b0);

        // alternating difference, first carried on from the sum vector
        set_mode(rfps_pkg::MODE_ALT);
        send_elem(32'd3, 1'b0);
        send_elem(VAL_MIN, 1'b0);
        send_elem(VAL_MAX, 1'b1);
        send_elem(VAL_ONES, 1'b0);

        // each boolean fold in turn, one vector across all the mode changes
        for (int k = rfps_pkg::MODE_AND; k <= rfps_pkg::MODE_EQ; k++) begin
            set_mode(rfps_pkg::MODE_W'(k));
            send_elem(k[0] ? VAL_ONES : 32'h0000_0002, k == rfps_pkg::MODE_AND);
        end

        // unused mode codes give zero
        set_mode(MODE_SPARE_TOP);
        send_elem(VAL_MAX, 1'b1);
        send_elem(32'd5, 1'b0);

        // random phases, one mode each
        items_left = RANDOM_ITEMS;
        phase_idx  = 0;
        while (items_left > 0) begin
            if (phase_idx == 0) begin
                m = rfps_pkg::MODE_SUM;
            end else if (phase_idx == 1) begin
                m = rfps_pkg::MODE_EQ;
            end else if ($urandom_range(0, 11) == 0) begin
                m = $urandom_range(MODE_SPARE_LOW, MODE_SPARE_TOP);
            end else begin
                m = $urandom_range(rfps_pkg::MODE_SUM, rfps_pkg::MODE_EQ);
            end
            set_mode(m);
            steady_send = ($urandom_range(0, 4) == 0);
            phase_len   = $urandom_range(20, 80);
            // now and then the vector runs on through the mode change
            fresh       = ($urandom_range(0, 9) != 0);
            vec_left    = 0;
            bias        = $urandom_range(0, 4);
            repeat (phase_len) begin
                if (vec_left == 0) begin
                    vec_left = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12)
                                                            : $urandom_range(13, 48);
                    bias     = $urandom_range(0, 4);
                    first    = fresh;
                    fresh    = 1'b1;
                end else begin
                    first = ($urandom_range(0, 49) == 0);
                end
                send_elem(pick_value($urandom_range(0, 3) < bias), first);
                vec_left--;
                items_left--;
                if ($urandom_range(0, 299) == 0) begin
                    drain_results();
                end
            end
            phase_idx++;
        end
        steady_send = 1'b0;

        drain_results();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        if (scan_faults == 0) begin
            $display("PASS right_fold_prefix_scan_core");
        end else begin
            $display("FAIL right_fold_prefix_scan_core");
        end
        $finish;
    end

endmodule
